// ===== hdl/pdt_pkg.sv =====
// ----------------------------------------------------------------------------
// PD torque package
// Shared constants, register indexes and fixed widths for the PD torque block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdt_pkg;

	// Angles and torques are Q16.16
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned GAIN_W  = 31;
	localparam int unsigned TAU_W   = 48;
	localparam int unsigned ERR_W   = 20;

	// pi in Q16.16 and its double, used by the angle wrap
	localparam logic [ERR_W-1:0] Q_PI     = 20'd205887;
	localparam logic [18:0]      Q_TWO_PI = 19'd411774;

	// Bias that makes the wrap operand non-negative: pi plus 10431 turns
	localparam logic [33:0] Q_WRAP_BIAS  = 34'd4295420481;
	// floor(2^34 / two_pi), quotient estimate is low by at most one
	localparam logic [15:0] Q_WRAP_RECIP = 16'd41721;

	// Register reset values
	localparam logic [GAIN_W-1:0] Q_ONE = 31'd65536;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_TARGET_ANGLE  = 3'd0,
		CFG_PROP_GAIN     = 3'd1,
		CFG_DERIV_GAIN    = 3'd2,
		CFG_STALL_TORQUE  = 3'd3,
		CFG_NO_LOAD_SPEED = 3'd4,
		CFG_CONT_TORQUE   = 3'd5,
		CFG_GEAR_RATIO    = 3'd6
	} cfg_idx_t;

endpackage

`default_nettype wire

// ===== hdl/pd_torque_with_motor_envelope.sv =====
// ----------------------------------------------------------------------------
// PD torque with motor envelope
// PD joint torque clamped to a DC-motor torque-speed envelope.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with joint_angle and joint_velocity; the sample is taken on
//   that edge. busy stays low, so a new sample may be given every cycle.
//   Once through the pipeline, done is high for one cycle with torque and
//   limited; the receiver must take it then, results keep sample order.
//   Throughput is one sample per cycle. The pipeline is made of the two
//   one-bit-per-stage dividers (corner speed and envelope slope term, 32
//   stages each) plus the seven-stage PD law and nine stages of multiply,
//   clip and clamp.
//   Registers are written through cfg_wr_en, cfg_index and cfg_data while no
//   sample is in flight; indexes beyond the list are ignored.
//   Reset clears all valid bits, so no result is produced for a sample in
//   flight, and returns the registers to their reset values (gains zero,
//   motor values 1.0).
// ----------------------------------------------------------------------------
`default_nettype none

module pd_torque_with_motor_envelope (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] joint_angle,
	input  wire logic signed [31:0] joint_velocity,
	output logic                    done,
	output logic signed [31:0]      torque,
	output logic                    limited,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int unsigned GW = pdt_pkg::GAIN_W;
	localparam int unsigned TW = pdt_pkg::TAU_W;

	logic signed [31:0] target_q;
	logic [GW-1:0] kp_q, kd_q, stall_q, noload_q, cont_q, gear_q;
	logic [GW-1:0] stall_eff, speed_eff;

	logic pd_valid;
	logic signed [TW-1:0] pd_tau;
	logic signed [31:0] pd_vel;

	logic v_m1, v_m2;
	logic [61:0] sp_m1, sp_m2;
	logic signed [TW-1:0] tau_m1, tau_m2;
	logic signed [31:0] vel_m1, vel_m2;
	logic ovf_m2;

	logic cd_valid;
	logic [31:0] cd_q;
	logic cd_nz;
	logic [TW+32:0] cd_tag;

	logic v_c1, v_c2, v_c3;
	logic [30:0] corner_c1;
	logic big_c1;
	logic signed [31:0] vel_c1, c_c2;
	logic signed [TW-1:0] tau_c1, tau_c2, tau_c3;
	logic [62:0] prod_c3;
	logic neg_c3;

	logic td_valid;
	logic [31:0] td_q;
	logic td_nz;
	logic [TW:0] td_tag;

	logic v_t1, v_t2, v_t3, v_t4;
	logic signed [33:0] term_t1;
	logic signed [TW-1:0] tau_t1, tau_t2, tau_t3;
	logic signed [34:0] hi_t2, lo_t2;
	logic signed [TW-1:0] res_t3;
	logic lim_t3;
	logic signed [31:0] torque_t4;
	logic lim_t4;

	logic [32:0] csum;
	logic signed [32:0] vel_x, corner_x;
	logic [31:0] c_mag;
	logic [32:0] q_mag;
	logic signed [34:0] upper, lower, cont_x;
	logic signed [TW-1:0] res_lo, res_hi;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			kp_q     <= '0;
			kd_q     <= '0;
			stall_q  <= pdt_pkg::Q_ONE;
			noload_q <= pdt_pkg::Q_ONE;
			cont_q   <= pdt_pkg::Q_ONE;
			gear_q   <= pdt_pkg::Q_ONE;
		end else if (cfg_wr_en) begin
			case (pdt_pkg::cfg_idx_t'(cfg_index))
				pdt_pkg::CFG_TARGET_ANGLE:  target_q <= cfg_data;
				pdt_pkg::CFG_PROP_GAIN:     kp_q     <= cfg_data[GW-1:0];
				pdt_pkg::CFG_DERIV_GAIN:    kd_q     <= cfg_data[GW-1:0];
				pdt_pkg::CFG_STALL_TORQUE:  stall_q  <= cfg_data[GW-1:0];
				pdt_pkg::CFG_NO_LOAD_SPEED: noload_q <= cfg_data[GW-1:0];
				pdt_pkg::CFG_CONT_TORQUE:   cont_q   <= cfg_data[GW-1:0];
				pdt_pkg::CFG_GEAR_RATIO:    gear_q   <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	// Floor stall torque and no-load speed at one LSB
	assign stall_eff = (stall_q == '0) ? GW'(1) : stall_q;
	assign speed_eff = (noload_q == '0) ? GW'(1) : noload_q;

	// Never hold off a transfer
	assign busy = 1'b0;

	pdt_pd_law u_pd (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start),
		.joint_angle    (joint_angle),
		.joint_velocity (joint_velocity),
		.target_angle   (target_q),
		.prop_gain      (kp_q),
		.deriv_gain     (kd_q),
		.out_valid      (pd_valid),
		.tau            (pd_tau),
		.velocity       (pd_vel)
	);

	// Corner numerator and overflow check: quotient of 2^31 or more never clips
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_m1, v_m2} <= '0;
		end else begin
			{v_m1, v_m2} <= {pd_valid, v_m1};
		end
	end

	always_ff @(posedge clk) begin
		sp_m1  <= 62'(speed_eff) * 62'(cont_q);
		tau_m1 <= pd_tau;
		vel_m1 <= pd_vel;
		sp_m2  <= sp_m1;
		ovf_m2 <= (sp_m1[61:31] >= stall_eff);
		tau_m2 <= tau_m1;
		vel_m2 <= vel_m1;
	end

	pdt_udiv #(.SW(GW), .QW(32), .TW(TW + 33)) u_corner_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_m2),
		.dividend  (ovf_m2 ? 63'd0 : {1'b0, sp_m2}),
		.divisor   (stall_eff),
		.in_tag    ({tau_m2, vel_m2, ovf_m2}),
		.out_valid (cd_valid),
		.quotient  (cd_q),
		.rem_nz    (cd_nz),
		.out_tag   (cd_tag)
	);

	// Corner speed, velocity clip, slope numerator
	assign csum     = 33'(speed_eff) + 33'(cd_q);
	assign vel_x    = 33'(vel_c1);
	assign corner_x = $signed({2'b00, corner_c1});
	assign c_mag    = c_c2[31] ? 32'(-33'(c_c2)) : 32'(c_c2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_c1, v_c2, v_c3} <= '0;
		end else begin
			{v_c1, v_c2, v_c3} <= {cd_valid, v_c1, v_c2};
		end
	end

	always_ff @(posedge clk) begin
		corner_c1 <= csum[30:0];
		big_c1    <= cd_tag[0] | csum[32] | csum[31];
		vel_c1    <= cd_tag[32:1];
		tau_c1    <= cd_tag[TW+32:33];
		if (!big_c1 && vel_x > corner_x) begin
			c_c2 <= 32'(corner_x);
		end else if (!big_c1 && vel_x < -corner_x) begin
			c_c2 <= 32'(-corner_x);
		end else begin
			c_c2 <= vel_c1;
		end
		tau_c2  <= tau_c1;
		prod_c3 <= 63'(stall_eff) * 63'(c_mag);
		neg_c3  <= c_c2[31];
		tau_c3  <= tau_c2;
	end

	// Unused by the envelope: the gear ratio cancels
	logic gear_unused;
	assign gear_unused = ^gear_q ^ cd_nz;

	pdt_udiv #(.SW(GW), .QW(32), .TW(TW + 1)) u_term_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_c3),
		.dividend  (prod_c3),
		.divisor   (speed_eff),
		.in_tag    ({tau_c3, neg_c3 ^ (gear_unused & 1'b0)}),
		.out_valid (td_valid),
		.quotient  (td_q),
		.rem_nz    (td_nz),
		.out_tag   (td_tag)
	);

	// Floored slope term, bounds, clamp and saturate
	assign q_mag  = 33'(td_q) + ((td_tag[0] && td_nz) ? 33'd1 : 33'd0);
	assign cont_x = $signed({4'b0000, cont_q});
	assign upper  = $signed({4'b0000, stall_eff}) - 35'(term_t1);
	assign lower  = -$signed({4'b0000, stall_eff}) - 35'(term_t1);
	assign res_lo = (tau_t2 < TW'(lo_t2)) ? TW'(lo_t2) : tau_t2;
	assign res_hi = (res_lo > TW'(hi_t2)) ? TW'(hi_t2) : res_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_t1, v_t2, v_t3, v_t4} <= '0;
		end else begin
			{v_t1, v_t2, v_t3, v_t4} <= {td_valid, v_t1, v_t2, v_t3};
		end
	end

	always_ff @(posedge clk) begin
		term_t1 <= td_tag[0] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		tau_t1  <= td_tag[TW:1];
		hi_t2   <= (upper < cont_x) ? upper : cont_x;
		lo_t2   <= (lower > -cont_x) ? lower : -cont_x;
		tau_t2  <= tau_t1;
		res_t3  <= res_hi;
		lim_t3  <= (res_hi != tau_t2);
		if (res_t3 > TW'(32'sh7FFFFFFF)) begin
			torque_t4 <= 32'sh7FFFFFFF;
		end else if (res_t3 < TW'(-33'sh80000000)) begin
			torque_t4 <= 32'sh80000000;
		end else begin
			torque_t4 <= res_t3[31:0];
		end
		lim_t4 <= lim_t3;
	end

	assign done    = v_t4;
	assign torque  = torque_t4;
	assign limited = lim_t4;

endmodule

`default_nettype wire

// ===== hdl/pdt_udiv.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage; a tag travels alongside.
// The dividend's upper SW bits must be below the divisor, and the divisor
// must hold steady while an item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pdt_udiv #(
	parameter int unsigned SW = 31,
	parameter int unsigned QW = 32,
	parameter int unsigned TW = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [SW+QW-1:0] dividend,
	input  wire logic [SW-1:0]    divisor,
	input  wire logic [TW-1:0]    in_tag,
	output logic                  out_valid,
	output logic [QW-1:0]         quotient,
	output logic                  rem_nz,
	output logic [TW-1:0]         out_tag
);

	logic          vld_s [1:QW];
	logic [SW-1:0] rem_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];
	logic [TW-1:0] tag_s [1:QW];
	logic [SW-1:0] rem_nx [QW];
	logic [QW-1:0] quo_nx [QW];

	// One restoring step: trial subtract, shift the quotient bit in as the dividend bit leaves
	function automatic logic [SW+QW-1:0] div_step(logic [SW-1:0] rem, logic [QW-1:0] quo,
			logic [SW-1:0] d);
		logic [SW:0]   trial;
		logic          ge;
		logic [SW-1:0] rem_n;
		trial = {rem, quo[QW-1]};
		ge    = (trial >= {1'b0, d});
		rem_n = ge ? SW'(trial - {1'b0, d}) : trial[SW-1:0];
		return {rem_n, quo[QW-2:0], ge};
	endfunction

	// Stage zero works straight from the inputs
	always_comb begin
		{rem_nx[0], quo_nx[0]} = div_step(dividend[SW+QW-1:QW], dividend[QW-1:0], divisor);
		for (int k = 1; k < QW; k++) begin
			{rem_nx[k], quo_nx[k]} = div_step(rem_s[k], quo_s[k], divisor);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= QW; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= QW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		tag_s[1] <= in_tag;
		for (int k = 2; k <= QW; k++) tag_s[k] <= tag_s[k-1];
		for (int k = 1; k <= QW; k++) begin
			rem_s[k] <= rem_nx[k-1];
			quo_s[k] <= quo_nx[k-1];
		end
	end

	assign out_valid = vld_s[QW];
	assign quotient  = quo_s[QW];
	assign rem_nz    = |rem_s[QW];
	assign out_tag   = tag_s[QW];

endmodule

`default_nettype wire

// ===== hdl/pdt_pd_law.sv =====
// ----------------------------------------------------------------------------
// PD control law
// Wraps the angle error into [-pi, pi) and forms the floored PD torque.
// Seven register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pdt_pd_law (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic signed [31:0]           joint_angle,
	input  wire logic signed [31:0]           joint_velocity,
	input  wire logic signed [31:0]           target_angle,
	input  wire logic [pdt_pkg::GAIN_W-1:0]   prop_gain,
	input  wire logic [pdt_pkg::GAIN_W-1:0]   deriv_gain,
	output logic                              out_valid,
	output logic signed [pdt_pkg::TAU_W-1:0]  tau,
	output logic signed [31:0]                velocity
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [31:0] ang_s1;
	logic signed [31:0] vel_s1, vel_s2, vel_s3, vel_s4, vel_s5, vel_s6, vel_s7;
	logic [33:0] x_s2, x_s3;
	logic [15:0] qe_s3;
	logic [19:0] r_s4;
	logic signed [pdt_pkg::ERR_W-1:0] err_s5;
	logic signed [51:0] pp_s6;
	logic signed [63:0] pd_s6;
	logic signed [pdt_pkg::TAU_W-1:0] tau_s7;

	logic signed [32:0] e_raw;
	logic [49:0] q_prod;
	logic [34:0] q_back;
	logic [19:0] r_fix;
	logic signed [63:0] diff;

	// Raw error, then bias so the remainder works on a non-negative value
	assign e_raw  = 33'(target_angle) - 33'(ang_s1);
	// Estimate the turn count by reciprocal
	assign q_prod = 50'(x_s2) * 50'(pdt_pkg::Q_WRAP_RECIP);
	assign q_back = 35'(qe_s3) * 35'(pdt_pkg::Q_TWO_PI);
	// One correction step brings the remainder below two pi
	assign r_fix  = (r_s4 >= 20'(pdt_pkg::Q_TWO_PI)) ? r_s4 - 20'(pdt_pkg::Q_TWO_PI) : r_s4;
	assign diff   = 64'(pp_s6) - pd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	always_ff @(posedge clk) begin
		ang_s1 <= joint_angle;
		vel_s1 <= joint_velocity;
		x_s2   <= 34'(e_raw) + pdt_pkg::Q_WRAP_BIAS;
		vel_s2 <= vel_s1;
		qe_s3  <= q_prod[49:34];
		x_s3   <= x_s2;
		vel_s3 <= vel_s2;
		r_s4   <= 20'(35'(x_s3) - q_back);
		vel_s4 <= vel_s3;
		err_s5 <= $signed(r_fix) - $signed(pdt_pkg::Q_PI);
		vel_s5 <= vel_s4;
		pp_s6  <= $signed({1'b0, prop_gain}) * err_s5;
		pd_s6  <= $signed({1'b0, deriv_gain}) * vel_s5;
		vel_s6 <= vel_s5;
		tau_s7 <= diff[63:16];
		vel_s7 <= vel_s6;
	end

	assign out_valid = v_s7;
	assign tau       = tau_s7;
	assign velocity  = vel_s7;

endmodule

`default_nettype wire

// ===== verif/pd_torque_with_motor_envelope_tb.sv =====
// ----------------------------------------------------------------------------
// PD torque with motor envelope testbench
// Writes register settings while the block is idle, sends joint samples and
// checks every torque result against a hand-worked value or an envelope
// predictor. Hand-worked rows run first, then predicted and random samples.
// ----------------------------------------------------------------------------
`default_nettype none

module pd_torque_with_motor_envelope_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint PI_LSB = 205887;
	localparam longint MAX32  = 64'sh7FFF_FFFF;
	localparam longint MIN32  = -64'sh8000_0000;
	localparam int     DRAIN_CYCLES = 90;

	typedef struct packed {
		logic signed [31:0] ang;
		logic signed [31:0] vel;
		logic               known;
		logic signed [31:0] tq;
		logic               lim;
	} sample_row_t;

	typedef struct packed {
		logic signed [31:0] tq;
		logic               lim;
	} torque_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] joint_angle = '0;
	logic signed [31:0] joint_velocity = '0;
	logic               done;
	logic signed [31:0] torque;
	logic               limited;
	logic               cfg_wr_en = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// Local copy of the registers
	longint tgt_r, kp_r, kd_r, stall_r, speed_r, cont_r, gear_r;

	torque_t pending_torque[$];
	int      fail_count = 0;
	int      idle_pct = 0;

	// Hand-worked rows under reset settings: gains zero, motor values 1.0
	sample_row_t reset_rows[8] = '{
		'{32'sd0,          32'sd0,          1'b1, 32'sd0,      1'b0},
		'{32'sh7FFF_FFFF,  32'sd0,          1'b1, 32'sd0,      1'b0},
		'{32'sh8000_0000,  32'sd0,          1'b1, 32'sd0,      1'b0},
		'{32'sd0,          32'sh7FFF_FFFF,  1'b1, -32'sd65536, 1'b1},
		'{32'sd0,          32'sh8000_0000,  1'b1, 32'sd65536,  1'b1},
		'{-32'sd205887,    32'sd0,          1'b1, 32'sd0,      1'b0},
		'{32'sd0,          32'sd131072,     1'b1, -32'sd65536, 1'b1},
		'{32'sd0,          32'sd65536,      1'b1, 32'sd0,      1'b0}
	};

	// Rows around the angle wrap and the field extremes, predicted
	sample_row_t edge_rows[12] = '{
		'{-32'sd205887,    32'sd0,          1'b0, 32'sd0, 1'b0},
		'{32'sd205887,     32'sd0,          1'b0, 32'sd0, 1'b0},
		'{-32'sd205886,    32'sd0,          1'b0, 32'sd0, 1'b0},
		'{32'sd205888,     32'sd0,          1'b0, 32'sd0, 1'b0},
		'{32'sh7FFF_FFFF,  32'sh7FFF_FFFF,  1'b0, 32'sd0, 1'b0},
		'{32'sh8000_0000,  32'sh8000_0000,  1'b0, 32'sd0, 1'b0},
		'{32'sh7FFF_FFFF,  32'sh8000_0000,  1'b0, 32'sd0, 1'b0},
		'{32'sh8000_0000,  32'sh7FFF_FFFF,  1'b0, 32'sd0, 1'b0},
		'{32'sd1,          -32'sd1,         1'b0, 32'sd0, 1'b0},
		'{-32'sd1,         32'sd1,          1'b0, 32'sd0, 1'b0},
		'{32'sd411774,     32'sd3,          1'b0, 32'sd0, 1'b0},
		'{-32'sd411774,    -32'sd3,         1'b0, 32'sd0, 1'b0}
	};

	pd_torque_with_motor_envelope i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.joint_angle    (joint_angle),
		.joint_velocity (joint_velocity),
		.done           (done),
		.torque         (torque),
		.limited        (limited),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #10 clk = ~clk;

	// floor division for a positive divisor
	function automatic longint floor_quot(longint x, longint d);
		longint q;
		q = x / d;
		if ((x % d) != 0 && x < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	// PD law clamped to the torque-speed envelope
	function automatic torque_t envelope_torque(longint ang, longint vel);
		longint e, err, tau, stall, speed, corner, c, term, hi, lo, res;
		torque_t r;
		e = tgt_r - ang;
		err = (e + PI_LSB) % (2 * PI_LSB);
		if (err < 0) begin
			err = err + 2 * PI_LSB;
		end
		err = err - PI_LSB;
		tau = floor_quot(kp_r * err - kd_r * vel, 65536);
		stall = (stall_r != 0) ? stall_r : 1;
		speed = (speed_r != 0) ? speed_r : 1;
		corner = speed + (speed * cont_r) / stall;
		c = vel;
		if (c > corner) begin
			c = corner;
		end
		if (c < -corner) begin
			c = -corner;
		end
		term = floor_quot(stall * c, speed);
		hi = stall - term;
		if (hi > cont_r) begin
			hi = cont_r;
		end
		lo = -stall - term;
		if (lo < -cont_r) begin
			lo = -cont_r;
		end
		res = tau;
		if (res < lo) begin
			res = lo;
		end
		if (res > hi) begin
			res = hi;
		end
		r.lim = (res != tau);
		if (res > MAX32) begin
			res = MAX32;
		end
		if (res < MIN32) begin
			res = MIN32;
		end
		r.tq = res[31:0];
		return r;
	endfunction

	task automatic write_reg(pdt_pkg::cfg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			pdt_pkg::CFG_TARGET_ANGLE:  tgt_r   = longint'(signed'(value));
			pdt_pkg::CFG_PROP_GAIN:     kp_r    = longint'(value[30:0]);
			pdt_pkg::CFG_DERIV_GAIN:    kd_r    = longint'(value[30:0]);
			pdt_pkg::CFG_STALL_TORQUE:  stall_r = longint'(value[30:0]);
			pdt_pkg::CFG_NO_LOAD_SPEED: speed_r = longint'(value[30:0]);
			pdt_pkg::CFG_CONT_TORQUE:   cont_r  = longint'(value[30:0]);
			default:                    gear_r  = longint'(value[30:0]);
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Drive one sample until transfer; push its expected torque
	task automatic send_sample(logic signed [31:0] ang, logic signed [31:0] vel,
			logic known, torque_t hand);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			@(posedge clk);
		end
		forever begin
			@(negedge clk);
			start          <= 1'b1;
			joint_angle    <= ang;
			joint_velocity <= vel;
			@(posedge clk);
			if (!busy) break;
		end
		pending_torque.push_back(known ? hand : envelope_torque(ang, vel));
	endtask

	// Hold the sender until every result is back
	task automatic hold_for_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_torque.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		hold_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_motor();
		case ($urandom_range(3))
			0: return $urandom_range(0, 4);
			1: return $urandom_range(1 << 14, 1 << 19);
			2: return $urandom;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(2))
			0: return $urandom_range(0, 1 << 20);
			1: return $urandom;
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		torque_t want;
		if (arst_n && done) begin
			if (pending_torque.size() == 0) begin
				$error("unexpected result: torque %0d limited %0d", torque, limited);
				fail_count++;
			end else begin
				want = pending_torque.pop_front();
				if (torque !== want.tq) begin
					$error("torque: expected %0d, got %0d", want.tq, torque);
					fail_count++;
				end
				if (limited !== want.lim) begin
					$error("limited: expected %0d, got %0d", want.lim, limited);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("pd_torque_with_motor_envelope_tb: FAIL");
		$finish;
	end

	initial begin
		torque_t hand;
		logic signed [31:0] ang, vel;
		tgt_r = 0; kp_r = 0; kd_r = 0;
		stall_r = 65536; speed_r = 65536; cont_r = 65536; gear_r = 65536;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings
		foreach (reset_rows[i]) begin
			hand.tq  = reset_rows[i].tq;
			hand.lim = reset_rows[i].lim;
			send_sample(reset_rows[i].ang, reset_rows[i].vel, 1'b1, hand);
		end
		settle();

		// Directed: strong gains, small motor, then wrap and extremes
		write_reg(pdt_pkg::CFG_PROP_GAIN, 32'h7FFF_FFFF);
		write_reg(pdt_pkg::CFG_DERIV_GAIN, 32'h0001_0000);
		write_reg(pdt_pkg::CFG_STALL_TORQUE, 32'h0000_0000);
		write_reg(pdt_pkg::CFG_NO_LOAD_SPEED, 32'h0000_0000);
		write_reg(pdt_pkg::CFG_CONT_TORQUE, 32'h7FFF_FFFF);
		write_reg(pdt_pkg::CFG_GEAR_RATIO, 32'h0000_0001);
		end_writes();
		foreach (edge_rows[i]) begin
			send_sample(edge_rows[i].ang, edge_rows[i].vel, 1'b0, hand);
		end
		settle();

		// Random phases; the first three settings are the extremes
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 57;
				2: idle_pct = 0;
				default: idle_pct = 23;
			endcase
			case (ph)
				0: begin
					for (int r = 0; r < 7; r++) begin
						write_reg(pdt_pkg::cfg_idx_t'(r), 32'hFFFF_FFFF);
					end
				end
				1: begin
					for (int r = 0; r < 7; r++) begin
						write_reg(pdt_pkg::cfg_idx_t'(r), 32'h0000_0000);
					end
				end
				2: begin
					write_reg(pdt_pkg::CFG_TARGET_ANGLE, 32'h8000_0000);
					write_reg(pdt_pkg::CFG_PROP_GAIN, 32'h7FFF_FFFF);
					write_reg(pdt_pkg::CFG_DERIV_GAIN, 32'h7FFF_FFFF);
					write_reg(pdt_pkg::CFG_STALL_TORQUE, 32'h0000_0001);
					write_reg(pdt_pkg::CFG_NO_LOAD_SPEED, 32'h7FFF_FFFF);
					write_reg(pdt_pkg::CFG_CONT_TORQUE, 32'h0000_0000);
					write_reg(pdt_pkg::CFG_GEAR_RATIO, 32'h7FFF_FFFF);
				end
				default: begin
					write_reg(pdt_pkg::CFG_TARGET_ANGLE, $urandom);
					write_reg(pdt_pkg::CFG_PROP_GAIN, rand_gain());
					write_reg(pdt_pkg::CFG_DERIV_GAIN, rand_gain());
					write_reg(pdt_pkg::CFG_STALL_TORQUE, rand_motor());
					write_reg(pdt_pkg::CFG_NO_LOAD_SPEED, rand_motor());
					write_reg(pdt_pkg::CFG_CONT_TORQUE, rand_motor());
					write_reg(pdt_pkg::CFG_GEAR_RATIO, $urandom);
				end
			endcase
			end_writes();
			for (int n = 0; n < 140; n++) begin
				// Half the angles near the target so the wrap stays in play
				if ($urandom_range(1)) begin
					ang = 32'(tgt_r + longint'($urandom_range(0, 8 * 205887)) - 4 * PI_LSB);
				end else begin
					ang = $urandom;
				end
				case ($urandom_range(3))
					0: vel = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
					1: vel = $urandom;
					2: vel = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
					default: vel = $signed($urandom_range(0, 64)) - 32;
				endcase
				send_sample(ang, vel, 1'b0, hand);
				if (ph == 5 && n == 70) begin
					hold_for_results();
				end
			end
			settle();
		end

		if (fail_count == 0 && pending_torque.size() == 0) begin
			$display("pd_torque_with_motor_envelope_tb: PASS");
		end else begin
			$display("pd_torque_with_motor_envelope_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/pdt_pkg.sv
hdl/pdt_udiv.sv
hdl/pdt_pd_law.sv
hdl/pd_torque_with_motor_envelope.sv
verif/pd_torque_with_motor_envelope_tb.sv
